[sv/lito_pkg.sv]
// ----------------------------------------------------------------------------
// lito_pkg
// Shared types and constants for the linear index to strided offset block.
// ----------------------------------------------------------------------------
package lito_pkg;

    localparam int DIMS      = 4;
    localparam int IDX_W     = 64;
    localparam int EXT_W     = 32;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_EXTENT0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END     = 4'd8;

    // Data handed from cell to cell along the chain.
    typedef struct packed {
        logic             vld;
        logic [EXT_W-1:0] rem;
        logic [IDX_W-1:0] quo;
        logic [IDX_W-1:0] acc;
    } cell_t;

endpackage

[sv/lito_div_cell.sv]
// ----------------------------------------------------------------------------
// lito_div_cell
// One restoring division step: brings down one index bit, emits one quotient bit.
// ----------------------------------------------------------------------------
module lito_div_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [lito_pkg::EXT_W-1:0] ext,
    input  lito_pkg::cell_t        d_in,
    output lito_pkg::cell_t        d_out
);

    lito_pkg::cell_t            cell_reg;
    lito_pkg::cell_t            cell_next;
    logic [lito_pkg::EXT_W:0]   trial;
    logic [lito_pkg::EXT_W:0]   diff;
    logic                       qbit;

    always_comb
    begin
        trial = {d_in.rem, d_in.quo[lito_pkg::IDX_W-1]};
        diff  = trial - {1'b0, ext};
        qbit  = (trial >= {1'b0, ext});
        cell_next     = d_in;
        cell_next.rem = qbit ? diff[lito_pkg::EXT_W-1:0] : trial[lito_pkg::EXT_W-1:0];
        cell_next.quo = {d_in.quo[lito_pkg::IDX_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

[sv/lito_mac.sv]
// ----------------------------------------------------------------------------
// lito_mac
// Multiplies a finished digit by its signed stride and adds it to the offset.
// ----------------------------------------------------------------------------
module lito_mac (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [lito_pkg::EXT_W-1:0] stride,
    input  lito_pkg::cell_t        d_in,
    output lito_pkg::cell_t        d_out
);

    logic                          vld_reg;
    logic [lito_pkg::IDX_W-1:0]    quo_reg;
    logic [lito_pkg::IDX_W-1:0]    acc_reg;
    logic [lito_pkg::IDX_W-1:0]    prod_reg;
    logic [lito_pkg::IDX_W:0]      prod_next;
    lito_pkg::cell_t               out_reg;
    lito_pkg::cell_t               out_next;

    // The digit is unsigned and the stride signed; the low 64 bits are kept.
    assign prod_next = 65'($signed({1'b0, d_in.rem}) * $signed(stride));

    always_comb
    begin
        out_next.vld = vld_reg;
        out_next.rem = '0;
        out_next.quo = quo_reg;
        out_next.acc = acc_reg + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            quo_reg  <= '0;
            acc_reg  <= '0;
            prod_reg <= '0;
            out_reg  <= '0;
        end
        else if (en)
        begin
            vld_reg  <= d_in.vld;
            quo_reg  <= d_in.quo;
            acc_reg  <= d_in.acc;
            prod_reg <= prod_next[lito_pkg::IDX_W-1:0];
            out_reg  <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

[sv/lito_dim.sv]
// ----------------------------------------------------------------------------
// lito_dim
// One dimension: a chain of division cells followed by the multiply-add.
// ----------------------------------------------------------------------------
module lito_dim (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [lito_pkg::EXT_W-1:0] extent,
    input  logic [lito_pkg::EXT_W-1:0] stride,
    input  lito_pkg::cell_t        d_in,
    output lito_pkg::cell_t        d_out
);

    lito_pkg::cell_t              chain [lito_pkg::IDX_W+1];
    logic [lito_pkg::EXT_W-1:0]   ext_eff;

    // A zero extent behaves as an extent of one.
    assign ext_eff  = (extent == '0) ? lito_pkg::EXT_W'(1) : extent;
    assign chain[0] = d_in;

    for (genvar i = 0; i < lito_pkg::IDX_W; i++)
    begin : g_cell
        lito_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .ext   (ext_eff),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    lito_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .stride (stride),
        .d_in   (chain[lito_pkg::IDX_W]),
        .d_out  (d_out)
    );

endmodule

[sv/linear_index_to_strided_offset.sv]
// ----------------------------------------------------------------------------
// linear_index_to_strided_offset
// Splits a linear index over the configured extents and sums digit times stride.
// ----------------------------------------------------------------------------
// Each dimension is a chain of 64 one-bit division cells plus two registered
// multiply-add stages. Throughput: one transaction per cycle unless the output
// stalls; the whole chain holds while a result waits on a stalled output.
// Reset clears valid bits, extents to 1, strides to 0.
module linear_index_to_strided_offset (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lito_pkg::IDX_W-1:0]         linear_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lito_pkg::IDX_W-1:0]         offset,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lito_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lito_pkg::EXT_W-1:0]         cfg_data
);

    logic [lito_pkg::EXT_W-1:0] extent_reg [lito_pkg::DIMS];
    logic [lito_pkg::EXT_W-1:0] stride_reg [lito_pkg::DIMS];
    lito_pkg::cell_t            stage [lito_pkg::DIMS+1];
    logic                       adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < lito_pkg::DIMS; k++)
            begin
                extent_reg[k] <= lito_pkg::EXT_W'(1);
                stride_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int k = 0; k < lito_pkg::DIMS; k++)
            begin
                if (cfg_index == lito_pkg::REG_EXTENT0 + lito_pkg::CFG_IDX_W'(k))
                begin
                    extent_reg[k] <= cfg_data;
                end
                if ((cfg_index == lito_pkg::REG_STRIDE0 + lito_pkg::CFG_IDX_W'(k))
                    && (cfg_index < lito_pkg::REG_END))
                begin
                    stride_reg[k] <= cfg_data;
                end
            end
        end
    end

    assign adv      = !(stage[lito_pkg::DIMS].vld && out_stall);
    assign in_stall = !adv;

    assign stage[0] = {in_valid, {lito_pkg::EXT_W{1'b0}}, linear_index,
                       {lito_pkg::IDX_W{1'b0}}};

    // The innermost dimension is split off first.
    for (genvar g = 0; g < lito_pkg::DIMS; g++)
    begin : g_dim
        lito_dim u_dim (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv),
            .extent (extent_reg[lito_pkg::DIMS-1-g]),
            .stride (stride_reg[lito_pkg::DIMS-1-g]),
            .d_in   (stage[g]),
            .d_out  (stage[g+1])
        );
    end

    assign out_valid = stage[lito_pkg::DIMS].vld;
    assign offset    = stage[lito_pkg::DIMS].acc;

endmodule

[bench/linear_index_to_strided_offset_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_index_to_strided_offset_tb
// Drives flat indices through the offset generator under several extent and
// stride settings, with random sender bursts and receiver stalls. It predicts
// each offset by mixed-radix division and checks every result in order.
// ----------------------------------------------------------------------------
module linear_index_to_strided_offset_tb;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 300;

    class offset_scoreboard;
        logic [lito_pkg::EXT_W-1:0] extent [lito_pkg::DIMS];
        logic [lito_pkg::EXT_W-1:0] stride [lito_pkg::DIMS];
        logic [lito_pkg::IDX_W-1:0] expected_offsets[$];
        int errors;
        int results;

        function new();
            reset_regs();
            errors  = 0;
            results = 0;
        endfunction

        function void reset_regs();
            for (int d = 0; d < lito_pkg::DIMS; d++)
            begin
                extent[d] = 32'd1;
                stride[d] = 32'd0;
            end
        endfunction

        function void write_reg(logic [lito_pkg::CFG_IDX_W-1:0] idx,
                                logic [lito_pkg::EXT_W-1:0] data);
            if (idx >= lito_pkg::REG_EXTENT0 && idx < lito_pkg::REG_STRIDE0)
                extent[idx - lito_pkg::REG_EXTENT0] = data;
            else if (idx >= lito_pkg::REG_STRIDE0 && idx < lito_pkg::REG_END)
                stride[idx - lito_pkg::REG_STRIDE0] = data;
        endfunction

        // The innermost dimension takes the lowest digit; what is left after
        // dimension 0 is dropped.
        function logic [lito_pkg::IDX_W-1:0] strided_offset(logic [lito_pkg::IDX_W-1:0] index);
            logic [lito_pkg::IDX_W-1:0] rest;
            logic [lito_pkg::IDX_W-1:0] radix;
            logic [lito_pkg::IDX_W-1:0] digit;
            logic [lito_pkg::IDX_W-1:0] sum;
            rest = index;
            sum  = '0;
            for (int d = lito_pkg::DIMS - 1; d >= 0; d--)
            begin
                radix = (extent[d] == 0) ? 64'd1 : {32'd0, extent[d]};
                digit = rest % radix;
                rest  = rest / radix;
                sum   = sum + digit * {{32{stride[d][31]}}, stride[d]};
            end
            return sum;
        endfunction

        function void note_index(logic [lito_pkg::IDX_W-1:0] index);
            expected_offsets.push_back(strided_offset(index));
        endfunction

        function void check_offset(logic [lito_pkg::IDX_W-1:0] actual);
            logic [lito_pkg::IDX_W-1:0] want;
            results++;
            if (expected_offsets.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected offset, expected none actual %h", $time, actual);
                return;
            end
            want = expected_offsets.pop_front();
            if (want !== actual)
            begin
                errors++;
                $display("%0t: offset mismatch, expected %h actual %h", $time, want, actual);
            end
        endfunction

        function int pending();
            return expected_offsets.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [lito_pkg::IDX_W-1:0]     linear_index = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [lito_pkg::IDX_W-1:0]     offset;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lito_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lito_pkg::EXT_W-1:0]     cfg_data = '0;

    offset_scoreboard sb = new();
    int items_sent   = 0;
    int cfg_writes   = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;
    bit gaps_on      = 1'b1;
    int stall_mode   = 0;
    int stall_timer  = 0;

    linear_index_to_strided_offset i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .linear_index (linear_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .offset       (offset),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: check every accepted transaction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_offset(offset);
    end

    // Receiver stall pattern: free running, random, or long periodic holds.
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 400);
        end
        else
            stall_timer--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ((stall_timer % 16) < 5);
            default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: watchdog expired with %0d offsets pending", $time, sb.pending());
            $display("linear_index_to_strided_offset_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [lito_pkg::CFG_IDX_W-1:0] idx,
                             logic [lito_pkg::EXT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_index(logic [lito_pkg::IDX_W-1:0] index);
        in_valid     <= 1'b1;
        linear_index <= index;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_index(index);
        items_sent++;
    endtask

    // Sender with random bursts and gaps; gaps may be switched off for a phase.
    task automatic send_paced(logic [lito_pkg::IDX_W-1:0] index);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
            end
        end
        burst_left--;
        send_index(index);
    endtask

    task automatic set_dims(logic [lito_pkg::EXT_W-1:0] e0, logic [lito_pkg::EXT_W-1:0] e1,
                            logic [lito_pkg::EXT_W-1:0] e2, logic [lito_pkg::EXT_W-1:0] e3,
                            logic [lito_pkg::EXT_W-1:0] s0, logic [lito_pkg::EXT_W-1:0] s1,
                            logic [lito_pkg::EXT_W-1:0] s2, logic [lito_pkg::EXT_W-1:0] s3);
        write_reg(lito_pkg::REG_EXTENT0, e0);
        write_reg(lito_pkg::REG_EXTENT0 + 4'd1, e1);
        write_reg(lito_pkg::REG_EXTENT0 + 4'd2, e2);
        write_reg(lito_pkg::REG_EXTENT0 + 4'd3, e3);
        write_reg(lito_pkg::REG_STRIDE0, s0);
        write_reg(lito_pkg::REG_STRIDE0 + 4'd1, s1);
        write_reg(lito_pkg::REG_STRIDE0 + 4'd2, s2);
        write_reg(lito_pkg::REG_STRIDE0 + 4'd3, s3);
    endtask

    function automatic logic [lito_pkg::EXT_W-1:0] pick_extent();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return $urandom;
            2: return 32'd0;
            3: return 32'd1;
            default: return $urandom_range(2, 40);
        endcase
    endfunction

    // Number of elements the array holds, saturated at 64 bits.
    function automatic logic [lito_pkg::IDX_W-1:0] array_span();
        logic [2*lito_pkg::IDX_W-1:0] prod;
        prod = 1;
        for (int d = 0; d < lito_pkg::DIMS; d++)
        begin
            prod = prod * ((sb.extent[d] == 0) ? 1 : sb.extent[d]);
            if (prod[2*lito_pkg::IDX_W-1:lito_pkg::IDX_W] != 0)
                return '1;
        end
        return prod[lito_pkg::IDX_W-1:0];
    endfunction

    function automatic logic [lito_pkg::IDX_W-1:0] pick_index();
        logic [lito_pkg::IDX_W-1:0] span;
        logic [lito_pkg::IDX_W-1:0] r;
        span = array_span();
        r    = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1: return r;
            2: return span;
            3: return span - 1;
            4: return '0;
            default: return r % span;
        endcase
    endfunction

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values give offset zero.
        send_index('0);
        send_index('1);
        wait_drained();

        set_dims(32'd4, 32'd3, 32'd5, 32'd7, 32'd1, -32'sd2, 32'd100, -32'sd7);
        send_index(64'd0);
        send_index(64'd1);
        send_index(64'd419);
        send_index(64'd420);
        send_index(64'h8000_0000_0000_0000);
        send_index('1);
        wait_drained();

        // Register writes past the last register must have no effect.
        for (int i = lito_pkg::REG_END; i < 2**lito_pkg::CFG_IDX_W; i++)
            write_reg(lito_pkg::CFG_IDX_W'(i), $urandom);
        send_index(64'd123);
        wait_drained();

        // Extreme extents and strides, and an extent of zero.
        set_dims(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_index('1);
        send_index(64'hFFFF_FFFE);
        send_index(64'hFFFF_FFFF);
        send_index(64'h0000_0001_0000_0000);
        send_index(64'hFFFF_FFFE_FFFF_FFFF);
        send_index(64'h5555_5555_5555_5555);
        wait_drained();

        set_dims(32'd1, 32'd1, 32'd1, 32'd0,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_index(64'hAAAA_AAAA_AAAA_AAAA);
        send_index(64'd7);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            set_dims(pick_extent(), pick_extent(), pick_extent(), pick_extent(),
                     $urandom, $urandom, $urandom, $urandom);
            gaps_on = (phase % 3 != 2);
            for (int n = 0; n < 85; n++)
                send_paced(pick_index());
            wait_drained();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("Checked %0d offsets from %0d indices across %0d register writes,",
                 sb.results, items_sent, cfg_writes);
        $display("including zero and full-width extents and extreme signed strides.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("linear_index_to_strided_offset_tb: clean");
        else
            $display("linear_index_to_strided_offset_tb: errors");
        $finish;
    end

endmodule
